// ===== sv/frpc_pkg.sv =====
package frpc_pkg;

  localparam logic [32:0] FLASH_BASE_ADDR = 33'd134217728;
  localparam int SECTOR_COUNT = 24;
  localparam int MASK_WIDTH = 24;

  localparam logic [1:0] STATUS_COMPLETE  = 2'd0;
  localparam logic [1:0] STATUS_BOUNDARY  = 2'd1;
  localparam logic [1:0] STATUS_PROTECTED = 2'd2;

  localparam logic [2:0] REG_FLASH_SIZE_KB     = 3'd0;
  localparam logic [2:0] REG_SMALL_SECTOR_LOG2 = 3'd1;
  localparam logic [2:0] REG_DUAL_BANK         = 3'd2;
  localparam logic [2:0] REG_BANK_GAP          = 3'd3;
  localparam logic [2:0] REG_WRITABLE_MASK     = 3'd4;

  localparam logic [4:0] GAP_FIRST_SECTOR = 5'd8;
  localparam logic [4:0] GAP_LAST_SECTOR  = 5'd11;

  typedef struct packed {
    logic [31:0] start_address;
    logic [21:0] byte_count;
  } in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [4:0] first_sector;
    logic [4:0] last_sector;
  } out_t;

  typedef struct packed {
    logic [11:0]           flash_size_kb;
    logic [3:0]            small_sector_log2;
    logic                  dual_bank;
    logic                  bank_gap;
    logic [MASK_WIDTH-1:0] writable_mask;
  } cfg_t;

endpackage

// ===== sv/frpc_cfg.sv =====
module frpc_cfg import frpc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_wdata,
  output cfg_t        cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_FLASH_SIZE_KB:     cfg_nxt.flash_size_kb = cfg_wdata[11:0];
        REG_SMALL_SECTOR_LOG2: cfg_nxt.small_sector_log2 = cfg_wdata[3:0];
        REG_DUAL_BANK:         cfg_nxt.dual_bank = cfg_wdata[0];
        REG_BANK_GAP:          cfg_nxt.bank_gap = cfg_wdata[0];
        REG_WRITABLE_MASK:     cfg_nxt.writable_mask = cfg_wdata[MASK_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.flash_size_kb     <= 12'd1024;
      cfg_r.small_sector_log2 <= 4'd14;
      cfg_r.dual_bank         <= 1'b0;
      cfg_r.bank_gap          <= 1'b0;
      cfg_r.writable_mask     <= '1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== sv/frpc_map.sv =====
module frpc_map import frpc_pkg::*; (
  input  logic [31:0] off,
  input  cfg_t        cfg,
  output logic [4:0]  sector
);

  always_comb begin
    logic [31:0] q1;
    logic [31:0] q8;
    logic [31:0] kq;
    logic [31:0] rq1;
    logic [31:0] rq8;
    q1  = off >> cfg.small_sector_log2;
    q8  = q1 >> 3;
    kq  = cfg.bank_gap ? 32'd32 : 32'd64;
    rq1 = q1 - kq;
    rq8 = q8 - (kq >> 3);
    if (q1 < 32'd4) begin
      sector = q1[4:0];
    end else if (q1 < 32'd8) begin
      sector = 5'd4;
    end else if (cfg.dual_bank) begin
      if (q1 < kq) begin
        sector = q8[4:0] + 5'd4;
      end else if (rq1 < 32'd4) begin
        sector = rq1[4:0] + 5'd12;
      end else if (rq1 < 32'd8) begin
        sector = 5'd16;
      end else if (rq8 > 32'd15) begin
        sector = 5'd31;
      end else begin
        sector = rq8[4:0] + 5'd16;
      end
    end else if (q8 > 32'd27) begin
      sector = 5'd31;
    end else begin
      sector = q8[4:0] + 5'd4;
    end
  end

endmodule

// ===== sv/flash_region_protect_check.sv =====
// Steps: the start transfer loads the request; a zero count or a boundary error goes straight
// to the result; otherwise the first and last sectors are mapped and the sectors are scanned.
// One request at a time; busy stays high until the result cycle ends, so the next start is
// taken only once the block is back in idle.
// Synchronous active-low reset returns to idle and loads the register defaults.
// out_valid is a one-cycle strobe; the receiver cannot stall it.
module flash_region_protect_check import frpc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_t         in_data,
  output logic        out_valid,
  output out_t        out_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_wdata
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_BOUND = 6'b000010,
    S_MAPF  = 6'b000100,
    S_MAPL  = 6'b001000,
    S_SCAN  = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  cfg_t        cfg;
  state_t      state_r, state_nxt;
  logic [31:0] addr_r, addr_nxt;
  logic [21:0] len_r, len_nxt;
  logic [31:0] off_r, off_nxt;
  logic [4:0]  first_r, first_nxt;
  logic [4:0]  last_r, last_nxt;
  logic [4:0]  idx_r, idx_nxt;
  logic [1:0]  status_r, status_nxt;
  logic [4:0]  sector;
  logic [32:0] end_addr;
  logic [32:0] top_addr;
  logic [31:0] avail;
  logic        in_gap;

  frpc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  frpc_map u_map (
    .off    (off_r),
    .cfg    (cfg),
    .sector (sector)
  );

  assign end_addr = FLASH_BASE_ADDR + {11'd0, cfg.flash_size_kb, 10'd0};
  assign top_addr = {1'b0, addr_r} + {11'd0, len_r};

  always_comb begin
    for (int j = 0; j < 32; j++) begin
      if (j < SECTOR_COUNT && j < MASK_WIDTH) begin
        avail[j] = cfg.writable_mask[j];
      end else begin
        avail[j] = 1'b0;
      end
    end
  end

  assign in_gap = cfg.bank_gap && (idx_r inside {[GAP_FIRST_SECTOR:GAP_LAST_SECTOR]});

  always_comb begin
    state_nxt  = state_r;
    addr_nxt   = addr_r;
    len_nxt    = len_r;
    off_nxt    = off_r;
    first_nxt  = first_r;
    last_nxt   = last_r;
    idx_nxt    = idx_r;
    status_nxt = status_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          addr_nxt  = in_data.start_address;
          len_nxt   = in_data.byte_count;
          state_nxt = S_BOUND;
        end
      end
      S_BOUND: begin
        first_nxt  = 5'd0;
        last_nxt   = 5'd0;
        status_nxt = STATUS_COMPLETE;
        off_nxt    = addr_r - FLASH_BASE_ADDR[31:0];
        if (len_r == 22'd0) begin
          state_nxt = S_DONE;
        end else if ({1'b0, addr_r} < FLASH_BASE_ADDR || top_addr > end_addr) begin
          status_nxt = STATUS_BOUNDARY;
          state_nxt  = S_DONE;
        end else begin
          state_nxt = S_MAPF;
        end
      end
      S_MAPF: begin
        first_nxt = sector;
        idx_nxt   = sector;
        off_nxt   = off_r + {10'd0, len_r} - 32'd1;
        state_nxt = S_MAPL;
      end
      S_MAPL: begin
        last_nxt  = sector;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (idx_r > last_r) begin
          state_nxt = S_DONE;
        end else if (!in_gap && !avail[idx_r]) begin
          status_nxt = STATUS_PROTECTED;
          state_nxt  = S_DONE;
        end else if (idx_r == last_r) begin
          state_nxt = S_DONE;
        end else begin
          idx_nxt = idx_r + 5'd1;
        end
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r   <= addr_nxt;
    len_r    <= len_nxt;
    off_r    <= off_nxt;
    first_r  <= first_nxt;
    last_r   <= last_nxt;
    idx_r    <= idx_nxt;
    status_r <= status_nxt;
  end

  assign busy                  = (state_r != S_IDLE);
  assign out_valid             = (state_r == S_DONE);
  assign out_data.status       = status_r;
  assign out_data.first_sector = first_r;
  assign out_data.last_sector  = last_r;

endmodule

// ===== tb/flash_region_protect_check_test.sv =====
`timescale 1ns / 1ps

module flash_region_protect_check_test;
  import frpc_pkg::*;

  localparam longint unsigned REGION_BASE = FLASH_BASE_ADDR;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int PHASE_ITEMS = 220;
  localparam int SETTLE_CYCLES = 8;
  localparam logic [2:0] REG_LAST = REG_WRITABLE_MASK;

  class region_status_board;
    out_t expected_status[$];
    int errors;
    bit [11:0] size_kb;
    bit [3:0] sector_log2;
    bit dual;
    bit gap;
    bit [MASK_WIDTH-1:0] mask;

    function new();
      errors = 0;
      size_kb = 12'd1024;
      sector_log2 = 4'd14;
      dual = 1'b0;
      gap = 1'b0;
      mask = 24'hFFFFFF;
    endfunction

    function void write_reg(logic [2:0] idx, logic [23:0] val);
      case (idx)
        REG_FLASH_SIZE_KB: size_kb = val[11:0];
        REG_SMALL_SECTOR_LOG2: sector_log2 = val[3:0];
        REG_DUAL_BANK: dual = val[0];
        REG_BANK_GAP: gap = val[0];
        REG_WRITABLE_MASK: mask = val[MASK_WIDTH-1:0];
        default: ;
      endcase
    endfunction

    function longint unsigned sector_of(longint unsigned off);
      longint unsigned s;
      longint unsigned bank;
      longint unsigned r;
      longint unsigned sec;
      s = 64'd1 << sector_log2;
      if (off < 4 * s) begin
        sec = off / s;
      end else if (off < 8 * s) begin
        sec = 4;
      end else if (dual) begin
        bank = gap ? 32 * s : 64 * s;
        if (off < bank) begin
          sec = off / (8 * s) + 4;
        end else begin
          r = off - bank;
          if (r < 4 * s) begin
            sec = r / s + 12;
          end else if (r < 8 * s) begin
            sec = 16;
          end else begin
            sec = r / (8 * s) + 16;
          end
        end
      end else begin
        sec = off / (8 * s) + 4;
      end
      if (sec > 31) sec = 31;
      return sec;
    endfunction

    function out_t predict_status(in_t req);
      out_t res;
      longint unsigned addr;
      longint unsigned len;
      longint unsigned lim;
      longint unsigned first;
      longint unsigned last;
      longint unsigned i;
      res = '0;
      addr = req.start_address;
      len = req.byte_count;
      lim = REGION_BASE + (longint'(size_kb) << 10);
      if (len == 0) return res;
      if (addr < REGION_BASE || addr + len > lim) begin
        res.status = STATUS_BOUNDARY;
        return res;
      end
      first = sector_of(addr - REGION_BASE);
      last = sector_of(addr + len - 1 - REGION_BASE);
      res.status = STATUS_COMPLETE;
      for (i = first; i <= last; i++) begin
        if (gap && (i inside {[GAP_FIRST_SECTOR:GAP_LAST_SECTOR]})) continue;
        if (i >= SECTOR_COUNT || i >= MASK_WIDTH) begin
          res.status = STATUS_PROTECTED;
          break;
        end
        if (!mask[i]) begin
          res.status = STATUS_PROTECTED;
          break;
        end
      end
      res.first_sector = first[4:0];
      res.last_sector = last[4:0];
      return res;
    endfunction

    function void note_request(in_t req);
      expected_status.push_back(predict_status(req));
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= 10) $display("%s", msg);
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (expected_status.size() == 0) begin
        report($sformatf("unexpected result status=%0d first=%0d last=%0d",
                         got.status, got.first_sector, got.last_sector));
        return;
      end
      want = expected_status.pop_front();
      if (got.status !== want.status || got.first_sector !== want.first_sector ||
          got.last_sector !== want.last_sector) begin
        report($sformatf({"mismatch: expected status=%0d first=%0d last=%0d, ",
                          "got status=%0d first=%0d last=%0d"},
                         want.status, want.first_sector, want.last_sector,
                         got.status, got.first_sector, got.last_sector));
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  logic busy;
  in_t in_data;
  logic out_valid;
  out_t out_data;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [23:0] cfg_wdata;

  region_status_board sb;
  int cycle_count = 0;

  flash_region_protect_check i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1) sb.check_result(out_data);
  end

  task automatic send_request(in_t req, int unsigned gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (busy);
    sb.note_request(req);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [23:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.expected_status.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apply_settings(cfg_t c);
    write_reg(REG_FLASH_SIZE_KB, {12'($urandom), c.flash_size_kb});
    write_reg(REG_SMALL_SECTOR_LOG2, {20'($urandom), c.small_sector_log2});
    write_reg(REG_DUAL_BANK, {23'($urandom), c.dual_bank});
    write_reg(REG_BANK_GAP, {23'($urandom), c.bank_gap});
    write_reg(REG_LAST + 3'(1 + $urandom_range(0, 2)), 24'($urandom));
    write_reg(REG_WRITABLE_MASK, c.writable_mask);
    cfg_we <= 1'b0;
  endtask

  function automatic in_t random_request();
    in_t r;
    longint unsigned span;
    longint unsigned s;
    longint unsigned off;
    longint unsigned room;
    longint unsigned len;
    int unsigned pick;
    span = longint'(sb.size_kb) << 10;
    s = 64'd1 << sb.sector_log2;
    pick = $urandom_range(0, 99);
    r.start_address = $urandom;
    r.byte_count = 22'($urandom_range(0, 22'h3FFFFF));
    if (pick < 6) begin
      r.byte_count = '0;
    end else if (pick < 16) begin
    end else if (pick < 26) begin
      if ($urandom_range(0, 1)) begin
        r.start_address = 32'(REGION_BASE + span - $urandom_range(0, 64));
      end else begin
        r.start_address = 32'(REGION_BASE - $urandom_range(1, 64));
      end
      r.byte_count = 22'($urandom_range(1, 4096));
    end else if (span != 0) begin
      if ($urandom_range(0, 2) == 0) begin
        off = ($urandom_range(0, 127) * s + span - $urandom_range(0, 1)) % span;
      end else begin
        off = $urandom % span;
      end
      room = span - off;
      case ($urandom_range(0, 2))
        0: len = $urandom_range(1, 64);
        1: len = $urandom_range(1, 32'(16 * s));
        default: len = 1 + $urandom % room;
      endcase
      if (len > room) len = room;
      if (len > 22'h3FFFFF) len = 22'h3FFFFF;
      r.start_address = 32'(REGION_BASE + off);
      r.byte_count = 22'(len);
    end
    return r;
  endfunction

  function automatic logic [23:0] one_hole_mask();
    return 24'hFFFFFF & ~(24'h1 << $urandom_range(0, 23));
  endfunction

  initial begin
    cfg_t phases[9];
    sb = new();
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;

    phases[0] = '{12'd2048, 4'd14, 1'b1, 1'b0, 24'hFFFFFF};
    phases[1] = '{12'd1024, 4'd14, 1'b1, 1'b1, 24'hFFFFFF};
    phases[2] = '{12'd1024, 4'd14, 1'b0, 1'b1, one_hole_mask()};
    phases[3] = '{12'd4095, 4'd15, 1'b1, 1'b0, one_hole_mask()};
    phases[4] = '{12'd0, 4'd14, 1'b0, 1'b0, 24'h000000};
    phases[5] = '{12'd2048, 4'd12, 1'b0, 1'b0, 24'($urandom)};
    phases[6] = '{12'd512, 4'd0, 1'b1, 1'b1, one_hole_mask()};
    phases[7] = '{12'd1536, 4'd15, 1'b1, 1'b1, 24'h000000};
    phases[8] = '{12'($urandom), 4'($urandom), 1'($urandom), 1'($urandom), 24'($urandom)};

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_request('{32'h0000_0000, 22'd0}, 0);
    send_request('{32'hFFFF_FFFF, 22'd0}, 1);
    send_request('{32'(REGION_BASE - 1), 22'd1}, 0);
    send_request('{32'(REGION_BASE), 22'd1}, 2);
    send_request('{32'(REGION_BASE + 32'h000F_FFFF), 22'd1}, 0);
    send_request('{32'(REGION_BASE), 22'h10_0000}, 0);
    send_request('{32'(REGION_BASE), 22'h10_0001}, 3);
    send_request('{32'(REGION_BASE + 1), 22'h0F_FFFF}, 0);
    send_request('{32'hFFFF_FFFF, 22'h3F_FFFF}, 0);
    send_request('{32'h0000_0000, 22'h3F_FFFF}, 5);
    send_request('{32'(REGION_BASE + 32'h0000_FFFF), 22'd2}, 0);
    send_request('{32'(REGION_BASE + 32'h0001_FFFF), 22'd2}, 0);
    send_request('{32'(REGION_BASE + 32'h0005_5555), 22'h0A_AAAA}, 1);
    send_request('{32'(REGION_BASE + 32'h000A_AAAA), 22'h05_5555}, 0);
    send_request('{32'hF7FF_FFFF, 22'h15_5555}, 0);

    foreach (phases[p]) begin
      drain();
      apply_settings(phases[p]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_request(random_request(),
                     (n >= 100 && n < 150) ? 0 : $urandom_range(0, 5));
      end
    end

    drain();
    if (sb.errors == 0 && sb.expected_status.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
